/* rtl/p24_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// p24_pkg
// Shared types, constants and round functions of the 24-bit PRESENT decryptor.
// ----------------------------------------------------------------------------
package p24_pkg;

  // block and field widths
  localparam int unsigned BLOCK_W   = 24;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned NUM_NIBS  = BLOCK_W / NIB_W;
  localparam int unsigned KEY_IDX_W = 4;
  // wide enough for any key index and any round count up to 31
  localparam int unsigned IDX_CMP_W = KEY_IDX_W + 1;

  typedef logic [BLOCK_W-1:0] block_t;

  // item kinds
  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_DECRYPT = 1'b1
  } kind_e;

  // inverse 4-bit s-box
  localparam logic [NIB_W-1:0] INV_SBOX [16] = '{
    4'd5,  4'd14, 4'd15, 4'd8,  4'd12, 4'd1, 4'd2, 4'd13,
    4'd11, 4'd4,  4'd6,  4'd3,  4'd0,  4'd7, 4'd9, 4'd10
  };

  // inverse bit permutation, msb-first bit i = 6n+m goes to bit 4m+n
  function automatic block_t inv_perm(input block_t x);
    block_t y;
    y = '0;
    for (int n = 0; n < 4; n++) begin
      for (int m = 0; m < 6; m++) begin
        y[BLOCK_W-1-(m*4+n)] = x[BLOCK_W-1-(n*6+m)];
      end
    end
    return y;
  endfunction

  // inverse s-box on every nibble
  function automatic block_t inv_sub(input block_t x);
    block_t y;
    y = '0;
    for (int n = 0; n < NUM_NIBS; n++) begin
      y[n*NIB_W +: NIB_W] = INV_SBOX[x[n*NIB_W +: NIB_W]];
    end
    return y;
  endfunction

endpackage
`default_nettype wire

/* rtl/present24_decrypt.sv */
`default_nettype none
// A decrypt item passes through the input register and then the result register.
// Throughput: one item per cycle unless a held result stalls it; all rounds
// are unrolled between input and result register, so no unit is shared.
// A load item updates the subkey store as it leaves the input register.
// Reset clears the valid flags only; subkey slots hold garbage until loaded.
// ----------------------------------------------------------------------------
// present24_decrypt
// 24-bit PRESENT decryptor with a loadable round subkey store.
// ----------------------------------------------------------------------------
module present24_decrypt #(
  parameter int unsigned NUM_ROUNDS = 10
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [0:0]                      kind_i,
  input  wire  [p24_pkg::KEY_IDX_W-1:0]   key_index_i,
  input  wire  [p24_pkg::BLOCK_W-1:0]     key_value_i,
  input  wire  [p24_pkg::BLOCK_W-1:0]     ciphertext_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [p24_pkg::BLOCK_W-1:0]     plaintext_o
);

  localparam int unsigned CW = p24_pkg::IDX_CMP_W;

  // input stage
  logic                             s1_valid_q;
  p24_pkg::kind_e                   s1_kind_q;
  logic [p24_pkg::KEY_IDX_W-1:0]    s1_idx_q;
  p24_pkg::block_t                  s1_data_q;
  logic                             s1_adv;

  // subkey store, one slot per round plus the initial whitening key
  p24_pkg::block_t                  key_q [NUM_ROUNDS+1];
  logic                             key_we;

  // round chain
  p24_pkg::block_t                  st [NUM_ROUNDS+1];

  // result stage
  logic                             out_valid_q;
  logic                             out_valid_d;
  p24_pkg::block_t                  out_data_q;
  logic                             out_load;

  // input stage moves when empty, when the result slot is free or on a load
  assign s1_adv     = !s1_valid_q || !out_valid_q || out_ready_i ||
                      (s1_kind_q == p24_pkg::KIND_LOAD);
  assign in_ready_o = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload of the input stage, loads carry the key value in the data slot
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_kind_q <= p24_pkg::kind_e'(kind_i);
      s1_idx_q  <= key_index_i;
      s1_data_q <= (kind_i == p24_pkg::KIND_DECRYPT) ? ciphertext_i : key_value_i;
    end
  end

  // subkey write, indexes above the round count are dropped
  assign key_we = s1_valid_q && (s1_kind_q == p24_pkg::KIND_LOAD) &&
                  ({1'b0, s1_idx_q} <= CW'(NUM_ROUNDS));

  always_ff @(posedge clk_i) begin
    for (int e = 0; e <= NUM_ROUNDS; e++) begin
      if (key_we && ({1'b0, s1_idx_q} == CW'(e))) begin
        key_q[e] <= s1_data_q;
      end
    end
  end

  // initial whitening then the unrolled rounds
  assign st[0] = s1_data_q ^ key_q[NUM_ROUNDS];

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    p24_round u_round (
      .state_i (st[r-1]),
      .key_i   (key_q[NUM_ROUNDS-r]),
      .state_o (st[r])
    );
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    if (!out_valid_q || out_ready_i) begin
      out_load    = s1_valid_q && (s1_kind_q == p24_pkg::KIND_DECRYPT);
      out_valid_d = out_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= st[NUM_ROUNDS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign plaintext_o = out_data_q;

endmodule
`default_nettype wire

/* rtl/p24_round.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// p24_round
// One inverse round: bit permutation, nibble s-box, subkey xor.
// ----------------------------------------------------------------------------
module p24_round (
  input  wire  p24_pkg::block_t state_i,
  input  wire  p24_pkg::block_t key_i,
  output logic [p24_pkg::BLOCK_W-1:0] state_o
);

  // permute, substitute, whiten with the round subkey
  assign state_o = p24_pkg::inv_sub(p24_pkg::inv_perm(state_i)) ^ key_i;

endmodule
`default_nettype wire

/* rtl/p24_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// p24_checker
// Port-level checks of the decryptor, bound to present24_decrypt.
// ----------------------------------------------------------------------------
module p24_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_ready_o,
  input wire [0:0]                     kind_i,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input wire [p24_pkg::BLOCK_W-1:0]    plaintext_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(plaintext_o))
    else $error("result changed while stalled");

  // a fresh result must come from a decrypt item accepted earlier at the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && (kind_i == p24_pkg::KIND_DECRYPT), 2))
    else $error("result without a decrypt item");

  // a load item reaching an empty result slot produces nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i == p24_pkg::KIND_LOAD)) ##1 !out_valid_o
      |=> !out_valid_o)
    else $error("load item produced a result");

endmodule

bind present24_decrypt p24_checker u_p24_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .plaintext_o (plaintext_o)
);
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 24-bit PRESENT decryptor. Subkey loads and
// decrypt items go in over a valid/ready channel with random gaps. A
// scoreboard keeps its own subkey store and computes the expected plaintext
// of every accepted decrypt. Each result is checked in order against it.
// One long receiver stall forces the block to back up and stall its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NROUNDS   = 10;
  localparam int unsigned RAND_KEEP = 600;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned KEY_IDX_W = p24_pkg::KEY_IDX_W;

  typedef p24_pkg::block_t block_t;
  typedef p24_pkg::kind_e  kind_e;

  // inverse nibble substitution, indexed by the ciphertext-side nibble
  localparam logic [3:0] RSBOX [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [0:0]           kind_i      = '0;
  logic [KEY_IDX_W-1:0] key_index_i = '0;
  block_t               key_value_i = '0;
  block_t               ciphertext_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  block_t               plaintext_o;

  // expected plaintext tracking
  class plaintext_scoreboard;
    block_t      subkeys [NROUNDS+1];
    block_t      pending_pt [$];
    int unsigned mismatches;

    function new();
      foreach (subkeys[i]) subkeys[i] = '0;
      mismatches = 0;
    endfunction

    // accepted item: update subkey store or queue the decrypted block
    function void note_item(kind_e k, logic [KEY_IDX_W-1:0] idx, block_t kv,
                            block_t ct);
      block_t s;
      block_t t;
      if (k == p24_pkg::KIND_LOAD) begin
        if (idx <= NROUNDS) subkeys[idx] = kv;
        return;
      end
      s = ct ^ subkeys[NROUNDS];
      for (int r = 1; r <= NROUNDS; r++) begin
        // msb-first bit i moves to bit (i mod 6)*4 + i/6
        t = '0;
        for (int i = 0; i < 24; i++) t[23 - ((i % 6) * 4 + i / 6)] = s[23 - i];
        for (int n = 0; n < 6; n++) s[n*4 +: 4] = RSBOX[t[n*4 +: 4]];
        s ^= subkeys[NROUNDS - r];
      end
      pending_pt.push_back(s);
    endfunction

    // compare one result with the oldest expectation
    function void check_plaintext(block_t got);
      block_t want;
      if (pending_pt.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected plaintext %06h with nothing pending", got);
        return;
      end
      want = pending_pt.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("plaintext mismatch: expected %06h, got %06h", want, got);
      end
    endfunction
  endclass

  plaintext_scoreboard board;
  bit                  tx_calm;
  bit                  rx_calm;
  bit                  hold_req;
  int unsigned         rush_left;
  int unsigned         stall_left;

  present24_decrypt #(
    .NUM_ROUNDS (NROUNDS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .key_index_i  (key_index_i),
    .key_value_i  (key_value_i),
    .ciphertext_i (ciphertext_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .plaintext_o  (plaintext_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // result side: check on handshake, then stall a random number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_plaintext(plaintext_o);
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // random block with the extremes mixed in
  function automatic block_t rand_block();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return block_t'($urandom());
    endcase
  endfunction

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(kind_e k, logic [KEY_IDX_W-1:0] idx, block_t kv,
                           block_t ct);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    gap = (tx_calm || rush_left != 0) ? 0 : $urandom_range(0, 14);
    if (rush_left != 0) rush_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    key_index_i  <= idx;
    key_value_i  <= kv;
    ciphertext_i <= ct;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(k, idx, kv, ct);
  endtask

  // run limit
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    kind_e                k;
    logic [KEY_IDX_W-1:0] idx;
    int unsigned          kept;
    bit                   pressed;

    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out-of-range loads before any real one, then all-zero subkeys
    send_item(p24_pkg::KIND_LOAD, 4'd15, '1, '1);
    send_item(p24_pkg::KIND_LOAD, 4'd11, 24'hAAAAAA, '0);
    for (int i = 0; i <= NROUNDS; i++)
      send_item(p24_pkg::KIND_LOAD, KEY_IDX_W'(i), '0, '1);
    send_item(p24_pkg::KIND_DECRYPT, 4'd0, '0, '0);
    send_item(p24_pkg::KIND_DECRYPT, 4'd15, '1, '1);

    // all-ones at both ends of the schedule
    send_item(p24_pkg::KIND_LOAD, 4'd10, '1, '0);
    send_item(p24_pkg::KIND_LOAD, 4'd0, '1, '0);
    send_item(p24_pkg::KIND_DECRYPT, 4'd0, '0, '0);
    send_item(p24_pkg::KIND_DECRYPT, 4'd15, '1, '1);

    // ignored loads must leave the store untouched
    send_item(p24_pkg::KIND_LOAD, 4'd12, 24'h123456, '1);
    send_item(p24_pkg::KIND_LOAD, 4'd14, 24'h5A5A5A, '1);
    send_item(p24_pkg::KIND_DECRYPT, 4'd7, 24'h123456, 24'h800001);
    send_item(p24_pkg::KIND_DECRYPT, 4'd10, '0, 24'h7FFFFE);

    // random mix, mostly decrypts with fresh subkeys now and then
    kept    = 0;
    pressed = 1'b0;
    while (kept < RAND_KEEP) begin
      if (kept == RAND_KEEP / 2 && !pressed) begin
        pressed   = 1'b1;
        hold_req  = 1'b1;
        rush_left = 48;
      end
      k = ($urandom_range(0, 9) < 7) ? p24_pkg::KIND_DECRYPT : p24_pkg::KIND_LOAD;
      if (k == p24_pkg::KIND_DECRYPT)
        idx = KEY_IDX_W'($urandom());
      else if ($urandom_range(0, 7) == 0)
        idx = KEY_IDX_W'($urandom_range(11, 15));
      else
        idx = KEY_IDX_W'($urandom_range(0, NROUNDS));
      send_item(k, idx, rand_block(), rand_block());
      if (k == p24_pkg::KIND_DECRYPT || idx <= NROUNDS) kept++;
    end
    in_valid_i <= 1'b0;

    // drain and let stragglers show up
    while (board.pending_pt.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending_pt.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
